[design/sapd_pkg.sv]
package sapd_pkg;

  localparam int SMP_W      = 8;
  localparam int SUM_W      = 20;
  localparam int CNT_W      = 13;
  localparam int COL_W      = 12;
  localparam int LVL_W      = 13;
  localparam int CFG_W      = 13;
  localparam int FS_W       = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int MAX_GROUP  = 4096;
  localparam int MAX_WIDTH  = 4096;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int DIV_W      = 21;
  localparam int DIVR_W     = 13;
  localparam int DIV_CNT_W  = $clog2(DIV_W);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPP        = 2'd0,
    REG_WIDTH      = 2'd1,
    REG_HEIGHT     = 2'd2,
    REG_FULL_SCALE = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
    logic [COL_W-1:0] column;
  } grp_t;

  function automatic logic [CNT_W-1:0] eff_group(input logic [CFG_W-1:0] spp);
    logic [CNT_W-1:0] g;
    g = spp;
    if (spp == '0) g = CNT_W'(1);
    else if (spp > CFG_W'(MAX_GROUP)) g = CNT_W'(MAX_GROUP);
    return g;
  endfunction

  function automatic logic [CFG_W-1:0] eff_width(input logic [CFG_W-1:0] w_in);
    logic [CFG_W-1:0] w;
    w = w_in;
    if (w_in == '0) w = CFG_W'(1);
    else if (w_in > CFG_W'(MAX_WIDTH)) w = CFG_W'(MAX_WIDTH);
    return w;
  endfunction

endpackage

[design/sapd_front.sv]
module sapd_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [sapd_pkg::SMP_W-1:0]  sample,
  input  logic                        frame_end,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [sapd_pkg::CFG_W-1:0]  samples_per_pixel,
  input  logic [sapd_pkg::CFG_W-1:0]  screen_width,
  input  logic                        fifo_full,
  output logic                        push,
  output sapd_pkg::grp_t              push_data
);

  logic [sapd_pkg::SUM_W-1:0] group_sum;
  logic [sapd_pkg::CNT_W-1:0] group_count;
  logic [sapd_pkg::COL_W-1:0] next_column;

  logic                       accept;
  logic                       complete;
  logic [sapd_pkg::SUM_W-1:0] sum_new;
  logic [sapd_pkg::CNT_W-1:0] cnt_new;
  logic [sapd_pkg::CNT_W-1:0] g;
  logic [sapd_pkg::CFG_W-1:0] w;
  logic [sapd_pkg::COL_W-1:0] col;
  logic [sapd_pkg::CFG_W-1:0] col_inc;
  logic [sapd_pkg::COL_W-1:0] col_next;

  assign in_ready = !fifo_full;
  assign accept   = in_valid && in_ready;

  assign g        = sapd_pkg::eff_group(samples_per_pixel);
  assign w        = sapd_pkg::eff_width(screen_width);
  assign sum_new  = group_sum + sapd_pkg::SUM_W'(sample);
  assign cnt_new  = group_count + sapd_pkg::CNT_W'(1);
  assign complete = cnt_new >= g;

  // point lands in column 0 if the width shrank to or below the running column
  assign col      = ({1'b0, next_column} >= w) ? '0 : next_column;
  assign col_inc  = {1'b0, col} + sapd_pkg::CFG_W'(1);
  assign col_next = (col_inc >= w) ? '0 : col_inc[sapd_pkg::COL_W-1:0];

  assign push             = accept && complete;
  assign push_data.sum    = sum_new;
  assign push_data.count  = cnt_new;
  assign push_data.column = col;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_sum   <= '0;
      group_count <= '0;
      next_column <= '0;
    end else if (accept) begin
      if (complete || frame_end) begin
        group_sum   <= '0;
        group_count <= '0;
      end else begin
        group_sum   <= sum_new;
        group_count <= cnt_new;
      end
      if (complete) begin
        next_column <= col_next;
      end
    end
  end

endmodule

[design/sapd_fifo.sv]
module sapd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sapd_pkg::grp_t push_data,
  input  logic           pop,
  output sapd_pkg::grp_t pop_data,
  output logic           full,
  output logic           empty
);

  sapd_pkg::grp_t                mem [sapd_pkg::FIFO_DEPTH];
  logic [sapd_pkg::FIFO_AW-1:0]  wr_ptr;
  logic [sapd_pkg::FIFO_AW-1:0]  rd_ptr;
  logic [sapd_pkg::FIFO_AW:0]    count;

  assign full     = count == (sapd_pkg::FIFO_AW+1)'(sapd_pkg::FIFO_DEPTH);
  assign empty    = count == '0;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + sapd_pkg::FIFO_AW'(1);
      if (pop && !empty) rd_ptr <= rd_ptr + sapd_pkg::FIFO_AW'(1);
      priority case (1'b1)
        (push && !full) && !(pop && !empty): count <= count + (sapd_pkg::FIFO_AW+1)'(1);
        !(push && !full) && (pop && !empty): count <= count - (sapd_pkg::FIFO_AW+1)'(1);
        default:                             count <= count;
      endcase
    end
  end

endmodule

[design/sapd_div.sv]
module sapd_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sapd_pkg::DIV_W-1:0]  dividend,
  input  logic [sapd_pkg::DIVR_W-1:0] divisor,
  output logic                        done,
  output logic [sapd_pkg::DIV_W-1:0]  quotient
);

  logic                           busy;
  logic [sapd_pkg::DIV_CNT_W-1:0] step;
  logic [sapd_pkg::DIVR_W-1:0]    rem;
  logic [sapd_pkg::DIVR_W-1:0]    dvs;
  logic [sapd_pkg::DIVR_W:0]      trial;
  logic                           fits;

  // restoring division, one quotient bit per cycle
  assign trial = {rem, quotient[sapd_pkg::DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step     <= '0;
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        rem      <= fits ? sapd_pkg::DIVR_W'(trial - {1'b0, dvs})
                         : trial[sapd_pkg::DIVR_W-1:0];
        quotient <= {quotient[sapd_pkg::DIV_W-2:0], fits};
        step     <= step + sapd_pkg::DIV_CNT_W'(1);
        if (step == sapd_pkg::DIV_CNT_W'(sapd_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[design/sapd_back.sv]
module sapd_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        fifo_empty,
  input  sapd_pkg::grp_t              fifo_data,
  output logic                        pop,
  input  logic [sapd_pkg::CFG_W-1:0]  screen_height,
  input  logic [sapd_pkg::FS_W-1:0]   sample_full_scale,
  output logic [sapd_pkg::COL_W-1:0]  column,
  output logic [sapd_pkg::LVL_W-1:0]  level,
  output logic                        out_valid,
  input  logic                        out_ready
);

  typedef enum logic [1:0] {ST_IDLE, ST_AVG, ST_SCALE, ST_DONE} state_t;

  state_t                       state;
  logic [sapd_pkg::COL_W-1:0]   col_r;
  logic [sapd_pkg::LVL_W-1:0]   lvl_r;

  logic                         div_start;
  logic [sapd_pkg::DIV_W-1:0]   div_dividend;
  logic [sapd_pkg::DIVR_W-1:0]  div_divisor;
  logic                         div_done;
  logic [sapd_pkg::DIV_W-1:0]   div_quo;

  logic [sapd_pkg::FS_W-1:0]    fs;
  logic [sapd_pkg::SMP_W-1:0]   avg;
  logic                         sat;
  logic [sapd_pkg::DIV_W-1:0]   product;
  logic                         out_load;

  assign fs      = (sample_full_scale == '0) ? sapd_pkg::FS_W'(1) : sample_full_scale;
  assign avg     = div_quo[sapd_pkg::SMP_W-1:0];
  assign sat     = avg >= fs;
  assign product = {{(sapd_pkg::DIV_W-sapd_pkg::SMP_W){1'b0}}, avg} *
                   {{(sapd_pkg::DIV_W-sapd_pkg::CFG_W){1'b0}}, screen_height};
  assign out_load = (state == ST_DONE) && (!out_valid || out_ready);

  always_comb begin
    pop          = (state == ST_IDLE) && !fifo_empty;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    if (pop) begin
      div_start    = 1'b1;
      div_dividend = sapd_pkg::DIV_W'(fifo_data.sum);
      div_divisor  = fifo_data.count;
    end else if (state == ST_AVG && div_done && !sat) begin
      div_start    = 1'b1;
      div_dividend = product;
      div_divisor  = sapd_pkg::DIVR_W'(fs);
    end
  end

  sapd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            col_r <= fifo_data.column;
            state <= ST_AVG;
          end
        end
        ST_AVG: begin
          if (div_done) begin
            if (sat) begin
              lvl_r <= screen_height;
              state <= ST_DONE;
            end else begin
              state <= ST_SCALE;
            end
          end
        end
        ST_SCALE: begin
          if (div_done) begin
            lvl_r <= div_quo[sapd_pkg::LVL_W-1:0];
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            column <= col_r;
            level  <= lvl_r;
            state  <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[design/sample_average_pixel_decimator.sv]
// Flow: the last sample of a group pushes it into the queue, and the back end then runs
// two bit-serial divisions, average then scaling (only the average when it saturates).
// Throughput: one sample per cycle while the four-entry queue has room; the back end
// handles one group at a time and pops the next once its point is loaded for output.
// Reset: registers return to 1/640/480/255, the group sum, count and column clear.
module sample_average_pixel_decimator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sapd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sapd_pkg::CFG_W-1:0]      cfg_data,
  input  logic [sapd_pkg::SMP_W-1:0]      sample,
  input  logic                            frame_end,
  input  logic                            in_valid,
  output logic                            in_ready,
  output logic [sapd_pkg::COL_W-1:0]      column,
  output logic [sapd_pkg::LVL_W-1:0]      level,
  output logic                            out_valid,
  input  logic                            out_ready
);

  logic [sapd_pkg::CFG_W-1:0] samples_per_pixel;
  logic [sapd_pkg::CFG_W-1:0] screen_width;
  logic [sapd_pkg::CFG_W-1:0] screen_height;
  logic [sapd_pkg::FS_W-1:0]  sample_full_scale;

  logic           push;
  logic           pop;
  logic           fifo_full;
  logic           fifo_empty;
  sapd_pkg::grp_t push_data;
  sapd_pkg::grp_t pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_per_pixel <= sapd_pkg::CFG_W'(1);
      screen_width      <= sapd_pkg::CFG_W'(640);
      screen_height     <= sapd_pkg::CFG_W'(480);
      sample_full_scale <= sapd_pkg::FS_W'(255);
    end else if (cfg_we) begin
      unique case (sapd_pkg::cfg_reg_t'(cfg_index))
        sapd_pkg::REG_SPP:        samples_per_pixel <= cfg_data;
        sapd_pkg::REG_WIDTH:      screen_width      <= cfg_data;
        sapd_pkg::REG_HEIGHT:     screen_height     <= cfg_data;
        sapd_pkg::REG_FULL_SCALE: sample_full_scale <= cfg_data[sapd_pkg::FS_W-1:0];
        default: ;
      endcase
    end
  end

  sapd_front u_front (
    .clk               (clk),
    .rst               (rst),
    .sample            (sample),
    .frame_end         (frame_end),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .samples_per_pixel (samples_per_pixel),
    .screen_width      (screen_width),
    .fifo_full         (fifo_full),
    .push              (push),
    .push_data         (push_data)
  );

  sapd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (fifo_full),
    .empty     (fifo_empty)
  );

  sapd_back u_back (
    .clk               (clk),
    .rst               (rst),
    .fifo_empty        (fifo_empty),
    .fifo_data         (pop_data),
    .pop               (pop),
    .screen_height     (screen_height),
    .sample_full_scale (sample_full_scale),
    .column            (column),
    .level             (level),
    .out_valid         (out_valid),
    .out_ready         (out_ready)
  );

`ifndef NO_ASSERTIONS
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, level} <= {1'b0, screen_height}))
    else $error("level above screen height");

  a_column_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, column} < sapd_pkg::eff_width(screen_width)))
    else $error("column outside screen width");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !fifo_full)
    else $error("group pushed into full queue");

  a_group_sane: assert property (@(posedge clk) disable iff (rst)
    push |-> (push_data.count != '0 &&
              push_data.sum <= sapd_pkg::SUM_W'(255) * sapd_pkg::SUM_W'(push_data.count)))
    else $error("group sum inconsistent with count");
`endif

endmodule
